/* hw/rtl/knps_pkg.sv */
// ----------------------------------------------------------------------------
// knps_pkg
// Shared constants and types of the k-nearest point select block.
// ----------------------------------------------------------------------------
package knps_pkg;

  localparam int MAX_NEAREST_DEF = 8;
  localparam int COORD_BITS_DEF  = 24;
  localparam int ID_BITS_DEF     = 20;

  localparam int RANK_BITS      = 3;
  localparam int COUNT_BITS     = 4;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [COUNT_BITS-1:0] COUNT_RESET = 4'd3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_VIEWER_X       = 4'd0,
    REG_VIEWER_Y       = 4'd1,
    REG_VIEWER_Z       = 4'd2,
    REG_NEIGHBOR_COUNT = 4'd3
  } cfg_reg_e;

  // per-cycle command to every cell of the chain
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

/* hw/rtl/knps_ifs.sv */
// ----------------------------------------------------------------------------
// knps interfaces
// Point, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface knps_pt_if #(
  parameter int COORD_BITS = knps_pkg::COORD_BITS_DEF,
  parameter int ID_BITS    = knps_pkg::ID_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  logic [ID_BITS-1:0]           point_id;
  logic                         last_point;

  modport source (output valid, pos_x, pos_y, pos_z, point_id, last_point, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, point_id, last_point, output ready);
endinterface

interface knps_res_if #(
  parameter int ID_BITS   = knps_pkg::ID_BITS_DEF,
  parameter int DIST_BITS = 2 * knps_pkg::COORD_BITS_DEF + 2
) ();
  logic                           valid;
  logic                           ready;
  logic [knps_pkg::RANK_BITS-1:0] rank;
  logic [ID_BITS-1:0]             nearest_id;
  logic [DIST_BITS-1:0]           distance_sq;
  logic                           last_result;

  modport source (output valid, rank, nearest_id, distance_sq, last_result, input ready);
  modport sink (input valid, rank, nearest_id, distance_sq, last_result, output ready);
endinterface

interface knps_cfg_if ();
  logic                                valid;
  logic                                ready;
  logic [knps_pkg::CFG_INDEX_BITS-1:0] index;
  logic [knps_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/knps_cell.sv */
// ----------------------------------------------------------------------------
// knps_cell
// One slot of the sorted insertion chain: holds a distance and an id.
// ----------------------------------------------------------------------------
module knps_cell #(
  parameter int DIST_BITS = 2 * knps_pkg::COORD_BITS_DEF + 2,
  parameter int ID_BITS   = knps_pkg::ID_BITS_DEF
) (
  input  logic                 clk_i,
  input  knps_pkg::cell_ctrl_t ctrl_i,
  input  logic                 active_i,
  input  logic                 occ_i,
  input  logic [DIST_BITS-1:0] new_dist_i,
  input  logic [ID_BITS-1:0]   new_id_i,
  input  logic                 prev_cond_i,
  input  logic [DIST_BITS-1:0] prev_dist_i,
  input  logic [ID_BITS-1:0]   prev_id_i,
  input  logic [DIST_BITS-1:0] next_dist_i,
  input  logic [ID_BITS-1:0]   next_id_i,
  output logic                 cond_o,
  output logic [DIST_BITS-1:0] dist_o,
  output logic [ID_BITS-1:0]   id_o
);

  logic [DIST_BITS-1:0] dist_q, dist_d;
  logic [ID_BITS-1:0]   id_q, id_d;

  // new point belongs at or before this slot
  assign cond_o = !occ_i || (new_dist_i < dist_q);

  always_comb begin
    dist_d = dist_q;
    id_d   = id_q;
    if (ctrl_i.insert && active_i) begin
      if (prev_cond_i) begin
        dist_d = prev_dist_i;
        id_d   = prev_id_i;
      end else if (cond_o) begin
        dist_d = new_dist_i;
        id_d   = new_id_i;
      end
    end else if (ctrl_i.shift) begin
      dist_d = next_dist_i;
      id_d   = next_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    id_q   <= id_d;
  end

  assign dist_o = dist_q;
  assign id_o   = id_q;

endmodule

/* hw/rtl/knps_dist.sv */
// ----------------------------------------------------------------------------
// knps_dist
// Three-stage squared distance pipeline: abs difference, square, sum.
// ----------------------------------------------------------------------------
module knps_dist #(
  parameter int COORD_BITS = knps_pkg::COORD_BITS_DEF,
  parameter int ID_BITS    = knps_pkg::ID_BITS_DEF,
  localparam int DistBits  = 2 * COORD_BITS + 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic signed [COORD_BITS-1:0] pos_z_i,
  input  logic signed [COORD_BITS-1:0] view_x_i,
  input  logic signed [COORD_BITS-1:0] view_y_i,
  input  logic signed [COORD_BITS-1:0] view_z_i,
  input  logic [ID_BITS-1:0]           id_i,
  input  logic                         last_i,
  output logic                         valid_o,
  output logic [DistBits-1:0]          dist_o,
  output logic [ID_BITS-1:0]           id_o,
  output logic                         last_o
);

  logic signed [COORD_BITS:0] dx, dy, dz;
  logic [COORD_BITS-1:0]      ax_d, ay_d, az_d;
  logic [COORD_BITS-1:0]      ax_q, ay_q, az_q;
  logic [2*COORD_BITS-1:0]    sx_q, sy_q, sz_q;
  logic [DistBits-1:0]        sum_q;
  logic [2:0]                 valid_q, last_q;
  logic [ID_BITS-1:0]         id1_q, id2_q, id3_q;

  assign dx = {pos_x_i[COORD_BITS-1], pos_x_i} - {view_x_i[COORD_BITS-1], view_x_i};
  assign dy = {pos_y_i[COORD_BITS-1], pos_y_i} - {view_y_i[COORD_BITS-1], view_y_i};
  assign dz = {pos_z_i[COORD_BITS-1], pos_z_i} - {view_z_i[COORD_BITS-1], view_z_i};

  assign ax_d = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
  assign ay_d = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
  assign az_d = dz[COORD_BITS] ? COORD_BITS'(-dz) : COORD_BITS'(dz);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      last_q  <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
      last_q  <= {last_q[1:0], last_i};
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q  <= ax_d;
    ay_q  <= ay_d;
    az_q  <= az_d;
    id1_q <= id_i;
    sx_q  <= (2*COORD_BITS)'(ax_q) * (2*COORD_BITS)'(ax_q);
    sy_q  <= (2*COORD_BITS)'(ay_q) * (2*COORD_BITS)'(ay_q);
    sz_q  <= (2*COORD_BITS)'(az_q) * (2*COORD_BITS)'(az_q);
    id2_q <= id1_q;
    sum_q <= DistBits'(sx_q) + DistBits'(sy_q) + DistBits'(sz_q);
    id3_q <= id2_q;
  end

  assign valid_o = valid_q[2];
  assign last_o  = last_q[2];
  assign dist_o  = sum_q;
  assign id_o    = id3_q;

endmodule

/* hw/rtl/k_nearest_point_select.sv */
// ----------------------------------------------------------------------------
// k_nearest_point_select
// Keeps the k nearest points to a viewer in a sorted chain of cells and
// reports them in rank order on the point marked last.
// Throughput: one point per cycle while the input is not held; a point reaches
// the chain through the registers of the squared distance pipeline.
// After a last point no point is taken until the report is unloaded from the
// chain; the unload waits while the sink stalls.
// Results leave one per cycle while the sink is ready, through a single output register.
// Reset clears the fill count and the handshake state and returns the
// configuration to its defaults.
// ----------------------------------------------------------------------------
module k_nearest_point_select #(
  parameter int MAX_NEAREST = knps_pkg::MAX_NEAREST_DEF,
  parameter int COORD_BITS  = knps_pkg::COORD_BITS_DEF,
  parameter int ID_BITS     = knps_pkg::ID_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  knps_pt_if.sink    pt_i,
  knps_res_if.source res_o,
  knps_cfg_if.sink   cfg_i
);

  localparam int DistBits = 2 * COORD_BITS + 2;
  localparam int CntBits  = $clog2(MAX_NEAREST + 1);
  localparam int KBits    = (CntBits > knps_pkg::COUNT_BITS) ? CntBits : knps_pkg::COUNT_BITS;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

  state_e                           state_q;
  logic signed [COORD_BITS-1:0]     view_x_q, view_y_q, view_z_q;
  logic [knps_pkg::COUNT_BITS-1:0]  count_q;
  logic [CntBits-1:0]               fill_q, rem_q, rank_q;
  logic                             hold_q;
  logic                             res_valid_q, res_last_q;
  logic [knps_pkg::RANK_BITS-1:0]   res_rank_q;
  logic [ID_BITS-1:0]               res_id_q;
  logic [DistBits-1:0]              res_dist_q;

  logic                             ins_valid, ins_last;
  logic [DistBits-1:0]              ins_dist;
  logic [ID_BITS-1:0]               ins_id;

  logic [KBits-1:0]                 count_w;
  logic [CntBits-1:0]               k_w, n_eff, n_new;
  logic                             taken, load_w;
  logic [MAX_NEAREST-1:0]           cond_vec, act_vec;
  logic [DistBits-1:0]              dist_w [MAX_NEAREST];
  logic [ID_BITS-1:0]               id_w [MAX_NEAREST];
  knps_pkg::cell_ctrl_t             ctrl;

  assign cfg_i.ready = 1'b1;
  assign pt_i.ready  = !hold_q;

  knps_dist #(
    .COORD_BITS (COORD_BITS),
    .ID_BITS    (ID_BITS)
  ) u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (pt_i.valid && pt_i.ready),
    .pos_x_i  (pt_i.pos_x),
    .pos_y_i  (pt_i.pos_y),
    .pos_z_i  (pt_i.pos_z),
    .view_x_i (view_x_q),
    .view_y_i (view_y_q),
    .view_z_i (view_z_q),
    .id_i     (pt_i.point_id),
    .last_i   (pt_i.last_point),
    .valid_o  (ins_valid),
    .dist_o   (ins_dist),
    .id_o     (ins_id),
    .last_o   (ins_last)
  );

  // active list length
  always_comb begin
    count_w = KBits'(count_q);
    if (count_w == '0) begin
      k_w = CntBits'(1);
    end else if (count_w > KBits'(MAX_NEAREST)) begin
      k_w = CntBits'(MAX_NEAREST);
    end else begin
      k_w = CntBits'(count_w);
    end
  end

  assign n_eff  = (fill_q < k_w) ? fill_q : k_w;
  assign taken  = |(cond_vec & act_vec);
  assign n_new  = (taken && (n_eff < k_w)) ? n_eff + CntBits'(1) : n_eff;
  assign load_w = (state_q == ST_DRAIN) && (rem_q != '0) && (!res_valid_q || res_o.ready);

  assign ctrl.insert = ins_valid;
  assign ctrl.shift  = load_w;

  for (genvar i = 0; i < MAX_NEAREST; i++) begin : g_cell
    logic                 prev_cond;
    logic [DistBits-1:0]  prev_dist, next_dist;
    logic [ID_BITS-1:0]   prev_id, next_id;

    if (i == 0) begin : g_first
      assign prev_cond = 1'b0;
      assign prev_dist = '0;
      assign prev_id   = '0;
    end else begin : g_mid
      assign prev_cond = cond_vec[i-1];
      assign prev_dist = dist_w[i-1];
      assign prev_id   = id_w[i-1];
    end

    if (i == MAX_NEAREST - 1) begin : g_tail
      assign next_dist = '0;
      assign next_id   = '0;
    end else begin : g_body
      assign next_dist = dist_w[i+1];
      assign next_id   = id_w[i+1];
    end

    assign act_vec[i] = CntBits'(i) < k_w;

    knps_cell #(
      .DIST_BITS (DistBits),
      .ID_BITS   (ID_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .active_i    (act_vec[i]),
      .occ_i       (CntBits'(i) < n_eff),
      .new_dist_i  (ins_dist),
      .new_id_i    (ins_id),
      .prev_cond_i (prev_cond),
      .prev_dist_i (prev_dist),
      .prev_id_i   (prev_id),
      .next_dist_i (next_dist),
      .next_id_i   (next_id),
      .cond_o      (cond_vec[i]),
      .dist_o      (dist_w[i]),
      .id_o        (id_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      view_x_q    <= '0;
      view_y_q    <= '0;
      view_z_q    <= '0;
      count_q     <= knps_pkg::COUNT_RESET;
      fill_q      <= '0;
      rem_q       <= '0;
      rank_q      <= '0;
      hold_q      <= 1'b0;
      res_valid_q <= 1'b0;
      res_last_q  <= 1'b0;
      res_rank_q  <= '0;
      res_id_q    <= '0;
      res_dist_q  <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          knps_pkg::REG_VIEWER_X:       view_x_q <= cfg_i.data[COORD_BITS-1:0];
          knps_pkg::REG_VIEWER_Y:       view_y_q <= cfg_i.data[COORD_BITS-1:0];
          knps_pkg::REG_VIEWER_Z:       view_z_q <= cfg_i.data[COORD_BITS-1:0];
          knps_pkg::REG_NEIGHBOR_COUNT: count_q  <= cfg_i.data[knps_pkg::COUNT_BITS-1:0];
          default: ;
        endcase
      end

      if (pt_i.valid && pt_i.ready && pt_i.last_point) begin
        hold_q <= 1'b1;
      end

      if (load_w) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (ins_valid) begin
            if (ins_last) begin
              fill_q  <= '0;
              rem_q   <= n_new;
              rank_q  <= '0;
              state_q <= ST_DRAIN;
            end else begin
              fill_q <= n_new;
            end
          end
        end
        ST_DRAIN: begin
          if (load_w) begin
            res_rank_q  <= knps_pkg::RANK_BITS'(rank_q);
            res_id_q    <= id_w[0];
            res_dist_q  <= dist_w[0];
            res_last_q  <= (rem_q == CntBits'(1));
            rem_q       <= rem_q - CntBits'(1);
            rank_q      <= rank_q + CntBits'(1);
            if (rem_q == CntBits'(1)) begin
              state_q <= ST_IDLE;
              hold_q  <= 1'b0;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.rank        = res_rank_q;
  assign res_o.nearest_id  = res_id_q;
  assign res_o.distance_sq = res_dist_q;
  assign res_o.last_result = res_last_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntBits'(MAX_NEAREST))
    else $error("fill count above chain length");

  a_drain_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> hold_q)
    else $error("input open while report is unloading");

  a_insert_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_valid |-> (state_q == ST_IDLE))
    else $error("point reached chain during report");

  a_report_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ins_valid && ins_last) |=> (rem_q != '0))
    else $error("empty report after last point");

endmodule
